// ===== hw/rtl/cpct_pkg.sv =====
// ----------------------------------------------------------------------------
// cpct_pkg: common tangents of two circles, shared types and constants
// Widths of the datapath, beat payload types and the saturating output add.
// ----------------------------------------------------------------------------
package cpct_pkg;

  // coordinate width of the ports
  localparam int CW = 24;
  // radius width
  localparam int RW = CW - 2;
  // center difference width (signed)
  localparam int DW = CW + 1;
  // signed tangent radius term r1 -+ r2
  localparam int KW = CW;
  // squared distance width (unsigned)
  localparam int SW = 2 * CW + 1;
  // square root result width
  localparam int QW = CW + 1;
  // sqrt remainder and trial width
  localparam int TW = SW + 2;
  // signed product width of the normal stage
  localparam int MW = DW + QW + 1;
  // signed normal vector width
  localparam int NW = SW + 1;
  // low and high split of the normal magnitude
  localparam int LW = CW + 1;
  localparam int HW = SW - LW;
  // dividend width and quotient width of the rounding divider
  localparam int PW = SW + RW + 1;
  localparam int QB = RW + 1;
  // slot field width, lane count and the slot codes of the first and last slot
  localparam int SLW = 2;
  localparam int NLANE = 4;
  localparam logic [SLW-1:0] SLOT_FIRST = 2'd0;
  localparam logic [SLW-1:0] SLOT_LAST  = 2'd3;

  // circle pair and slot of one beat
  typedef struct packed {
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [CW-1:0]  bx;
    logic [CW-1:0]  by;
    logic [RW-1:0]  r1;
    logic [RW-1:0]  r2;
    logic [SLW-1:0] slot;
  } geo_t;

  // payload carried alongside a beat after the pass select
  typedef struct packed {
    geo_t          geo;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [KW-1:0] k;
    logic [SW-1:0] s;
    logic          inner;
    logic          neg_t;
    logic          line_ok;
    logic [1:0]    neg;
  } pl_t;

  // add or subtract a rounded offset and clamp to the coordinate range
  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] base, logic [QB-1:0] mag,
                                            logic sub);
    logic [CW:0] sum;
    if (sub) begin
      sum = {base[CW-1], base} - (CW+1)'(mag);
    end else begin
      sum = {base[CW-1], base} + (CW+1)'(mag);
    end
    if (sum[CW] != sum[CW-1]) begin
      return sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return sum[CW-1:0];
  endfunction

endpackage

// ===== hw/rtl/circle_pair_common_tangents.sv =====
// ----------------------------------------------------------------------------
// circle_pair_common_tangents: touch points of the common tangents
// Splits each circle pair into four slot beats and runs them through a
// pipeline of squares, pass select, bit-per-stage square root, normal
// products and a bit-per-stage rounding divider.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   start_i, busy_o, first_*_i, second_*_i  taken when start_i & !busy_o
//  result    done_o, slot_index_o .. last_slot_o      one beat per done_o cycle
//
//  The slot serializer issues one beat per cycle; busy_o stays high until
//  the last slot beat of a pair is issued, when a new pair can be taken.
//  A beat passes S1 to S4, the square root, S5 to S9, the divider and the
//  output register; the four beats of a pair follow on consecutive cycles.
//  Reset clears the serializer and all stage valid bits; data is not reset.
//  The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module circle_pair_common_tangents (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [cpct_pkg::CW-1:0] first_center_x_i,
  input  logic [cpct_pkg::CW-1:0] first_center_y_i,
  input  logic [cpct_pkg::RW-1:0] first_radius_i,
  input  logic [cpct_pkg::CW-1:0] second_center_x_i,
  input  logic [cpct_pkg::CW-1:0] second_center_y_i,
  input  logic [cpct_pkg::RW-1:0] second_radius_i,
  output logic                    done_o,
  output logic [1:0]              slot_index_o,
  output logic                    line_valid_o,
  output logic [cpct_pkg::CW-1:0] touch_first_x_o,
  output logic [cpct_pkg::CW-1:0] touch_first_y_o,
  output logic [cpct_pkg::CW-1:0] touch_second_x_o,
  output logic [cpct_pkg::CW-1:0] touch_second_y_o,
  output logic                    last_slot_o
);

  localparam int CW = cpct_pkg::CW;
  localparam int RW = cpct_pkg::RW;
  localparam int DW = cpct_pkg::DW;
  localparam int KW = cpct_pkg::KW;
  localparam int SW = cpct_pkg::SW;
  localparam int QW = cpct_pkg::QW;
  localparam int TW = cpct_pkg::TW;
  localparam int MW = cpct_pkg::MW;
  localparam int NW = cpct_pkg::NW;
  localparam int LW = cpct_pkg::LW;
  localparam int HW = cpct_pkg::HW;
  localparam int PW = cpct_pkg::PW;
  localparam int QB = cpct_pkg::QB;
  localparam int NL = cpct_pkg::NLANE;
  localparam int LAT = QW + QB + 11;

  // --------------------------------------------------------------------------
  // Command capture and slot serializer
  // --------------------------------------------------------------------------
  cpct_pkg::geo_t geo_q, geo_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           issue_q, issue_d;
  logic           accept;

  assign busy_o = issue_q && (cnt_q != cpct_pkg::SLOT_LAST);
  assign accept = start_i && !busy_o;

  // advance the slot count, restart it on a new command
  always_comb begin
    cnt_d   = cnt_q;
    issue_d = issue_q;
    priority if (accept) begin
      cnt_d   = cpct_pkg::SLOT_FIRST;
      issue_d = 1'b1;
    end else if (issue_q) begin
      cnt_d   = cnt_q + 2'd1;
      issue_d = (cnt_q != cpct_pkg::SLOT_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= cpct_pkg::SLOT_FIRST;
      issue_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      issue_q <= issue_d;
    end
  end

  // gather the command fields into one beat
  always_comb begin
    geo_d      = '0;
    geo_d.ax   = first_center_x_i;
    geo_d.ay   = first_center_y_i;
    geo_d.r1   = first_radius_i;
    geo_d.bx   = second_center_x_i;
    geo_d.by   = second_center_y_i;
    geo_d.r2   = second_radius_i;
    geo_d.slot = cpct_pkg::SLOT_FIRST;
  end

  // hold the circle pair for its four beats
  always_ff @(posedge clk_i) begin
    if (accept) begin
      geo_q <= geo_d;
    end
  end

  // --------------------------------------------------------------------------
  // S1: center differences and radius terms
  // --------------------------------------------------------------------------
  logic           s1_vld_q;
  cpct_pkg::geo_t s1_geo_q, s1_geo_d;
  logic [DW-1:0]  s1_dx_q, s1_dy_q;
  logic [KW-1:0]  s1_ko_q, s1_ki_q;

  // tag the held pair with the current slot
  always_comb begin
    s1_geo_d      = geo_q;
    s1_geo_d.slot = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_geo_q <= s1_geo_d;
    s1_dx_q  <= {geo_q.bx[CW-1], geo_q.bx} - {geo_q.ax[CW-1], geo_q.ax};
    s1_dy_q  <= {geo_q.by[CW-1], geo_q.by} - {geo_q.ay[CW-1], geo_q.ay};
    s1_ko_q  <= KW'(geo_q.r1) - KW'(geo_q.r2);
    s1_ki_q  <= KW'(geo_q.r1) + KW'(geo_q.r2);
  end

  // --------------------------------------------------------------------------
  // S2: squares
  // --------------------------------------------------------------------------
  logic           s2_vld_q;
  cpct_pkg::geo_t s2_geo_q;
  logic [DW-1:0]  s2_dx_q, s2_dy_q;
  logic [KW-1:0]  s2_ko_q, s2_ki_q;
  logic [SW-1:0]  s2_dxx_q, s2_dyy_q, s2_kko_q, s2_kki_q;
  logic [2*DW-1:0] dxx_w, dyy_w;
  logic [2*KW-1:0] kko_w, kki_w;

  assign dxx_w = $signed(s1_dx_q) * $signed(s1_dx_q);
  assign dyy_w = $signed(s1_dy_q) * $signed(s1_dy_q);
  assign kko_w = $signed(s1_ko_q) * $signed(s1_ko_q);
  assign kki_w = $signed(s1_ki_q) * $signed(s1_ki_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_geo_q <= s1_geo_q;
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_ko_q  <= s1_ko_q;
    s2_ki_q  <= s1_ki_q;
    s2_dxx_q <= dxx_w[SW-1:0];
    s2_dyy_q <= dyy_w[SW-1:0];
    s2_kko_q <= SW'(kko_w);
    s2_kki_q <= SW'(kki_w);
  end

  // --------------------------------------------------------------------------
  // S3: squared distance
  // --------------------------------------------------------------------------
  logic           s3_vld_q;
  cpct_pkg::geo_t s3_geo_q;
  logic [DW-1:0]  s3_dx_q, s3_dy_q;
  logic [KW-1:0]  s3_ko_q, s3_ki_q;
  logic [SW-1:0]  s3_s_q, s3_kko_q, s3_kki_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_geo_q <= s2_geo_q;
    s3_dx_q  <= s2_dx_q;
    s3_dy_q  <= s2_dy_q;
    s3_ko_q  <= s2_ko_q;
    s3_ki_q  <= s2_ki_q;
    s3_s_q   <= s2_dxx_q + s2_dyy_q;
    s3_kko_q <= s2_kko_q;
    s3_kki_q <= s2_kki_q;
  end

  // --------------------------------------------------------------------------
  // S4: pick the pass of this slot, pack skipped passes downward
  // --------------------------------------------------------------------------
  logic          s4_vld_q;
  cpct_pkg::pl_t s4_pl_q, s4_pl_d;
  logic [SW-1:0] s4_rad_q, s4_rad_d;
  logic          ok_o, ok_i, s_zero;

  assign ok_o   = (s3_kko_q <= s3_s_q);
  assign ok_i   = (s3_kki_q <= s3_s_q);
  assign s_zero = (s3_s_q == '0);

  always_comb begin
    s4_pl_d       = '0;
    s4_pl_d.geo   = s3_geo_q;
    s4_pl_d.dx    = s3_dx_q;
    s4_pl_d.dy    = s3_dy_q;
    s4_pl_d.s     = s3_s_q;
    s4_pl_d.neg_t = s3_geo_q.slot[0];
    if (ok_o) begin
      s4_pl_d.inner   = s3_geo_q.slot[1];
      s4_pl_d.line_ok = !s3_geo_q.slot[1] || ok_i;
    end else begin
      s4_pl_d.inner   = 1'b1;
      s4_pl_d.line_ok = ok_i && !s3_geo_q.slot[1];
    end
    s4_pl_d.line_ok = s4_pl_d.line_ok && !s_zero;
    s4_pl_d.k       = s4_pl_d.inner ? s3_ki_q : s3_ko_q;
    s4_rad_d        = '0;
    if (s4_pl_d.line_ok) begin
      s4_rad_d = s3_s_q - (s4_pl_d.inner ? s3_kki_q : s3_kko_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_pl_q  <= s4_pl_d;
    s4_rad_q <= s4_rad_d;
  end

  // --------------------------------------------------------------------------
  // Square root, one result bit per stage
  // --------------------------------------------------------------------------
  logic          sq_vld_q [QW];
  cpct_pkg::pl_t sq_pl_q  [QW];
  logic [TW-1:0] sq_rem_q [QW];
  logic [QW-1:0] sq_res_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    localparam int B = QW - 1 - i;
    logic          vld_in;
    cpct_pkg::pl_t pl_in;
    logic [TW-1:0] rem_in, trial;
    logic [QW-1:0] res_in;

    if (i == 0) begin : g_head
      assign vld_in = s4_vld_q;
      assign pl_in  = s4_pl_q;
      assign rem_in = TW'(s4_rad_q);
      assign res_in = '0;
    end else begin : g_body
      assign vld_in = sq_vld_q[i-1];
      assign pl_in  = sq_pl_q[i-1];
      assign rem_in = sq_rem_q[i-1];
      assign res_in = sq_res_q[i-1];
    end

    // trial = (2*res + 2^B) * 2^B
    assign trial = (TW'(res_in) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i] <= 1'b0;
      end else begin
        sq_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_pl_q[i] <= pl_in;
      if (rem_in >= trial) begin
        sq_rem_q[i] <= rem_in - trial;
        sq_res_q[i] <= res_in | (QW'(1) << B);
      end else begin
        sq_rem_q[i] <= rem_in;
        sq_res_q[i] <= res_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // S5: normal products
  // --------------------------------------------------------------------------
  logic          s5_vld_q;
  cpct_pkg::pl_t s5_pl_q;
  logic [MW-1:0] s5_dxk_q, s5_dyk_q, s5_dxq_q, s5_dyq_q;
  cpct_pkg::pl_t sq_last_pl;
  logic [QW:0]   q_ext;

  assign sq_last_pl = sq_pl_q[QW-1];
  assign q_ext      = {1'b0, sq_res_q[QW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= sq_vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s5_pl_q  <= sq_last_pl;
    s5_dxk_q <= $signed(sq_last_pl.dx) * $signed(sq_last_pl.k);
    s5_dyk_q <= $signed(sq_last_pl.dy) * $signed(sq_last_pl.k);
    s5_dxq_q <= $signed(sq_last_pl.dx) * $signed(q_ext);
    s5_dyq_q <= $signed(sq_last_pl.dy) * $signed(q_ext);
  end

  // --------------------------------------------------------------------------
  // S6: combine into the normal vector, sign of q by tangent
  // --------------------------------------------------------------------------
  logic          s6_vld_q;
  cpct_pkg::pl_t s6_pl_q;
  logic [NW-1:0] s6_nx_q, s6_ny_q;
  logic [MW:0]   nx_w, ny_w;

  always_comb begin
    if (s5_pl_q.neg_t) begin
      nx_w = {s5_dxk_q[MW-1], s5_dxk_q} + {s5_dyq_q[MW-1], s5_dyq_q};
      ny_w = {s5_dyk_q[MW-1], s5_dyk_q} - {s5_dxq_q[MW-1], s5_dxq_q};
    end else begin
      nx_w = {s5_dxk_q[MW-1], s5_dxk_q} - {s5_dyq_q[MW-1], s5_dyq_q};
      ny_w = {s5_dyk_q[MW-1], s5_dyk_q} + {s5_dxq_q[MW-1], s5_dxq_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pl_q <= s5_pl_q;
    s6_nx_q <= nx_w[NW-1:0];
    s6_ny_q <= ny_w[NW-1:0];
  end

  // --------------------------------------------------------------------------
  // S7: magnitude and sign of the normal
  // --------------------------------------------------------------------------
  logic          s7_vld_q;
  cpct_pkg::pl_t s7_pl_q, s7_pl_d;
  logic [SW-1:0] s7_mx_q, s7_my_q;
  logic [NW-1:0] ax_w, ay_w;

  assign ax_w = s6_nx_q[NW-1] ? (~s6_nx_q + NW'(1)) : s6_nx_q;
  assign ay_w = s6_ny_q[NW-1] ? (~s6_ny_q + NW'(1)) : s6_ny_q;

  // carry the normal signs with the beat
  always_comb begin
    s7_pl_d     = s6_pl_q;
    s7_pl_d.neg = {s6_ny_q[NW-1], s6_nx_q[NW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_pl_q <= s7_pl_d;
    s7_mx_q <= ax_w[SW-1:0];
    s7_my_q <= ay_w[SW-1:0];
  end

  // --------------------------------------------------------------------------
  // S8: partial products with the radii, lanes x1 y1 x2 y2
  // --------------------------------------------------------------------------
  logic                s8_vld_q;
  cpct_pkg::pl_t       s8_pl_q;
  logic [LW+RW-1:0]    s8_lo_q [NL];
  logic [HW+RW-1:0]    s8_hi_q [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= s7_vld_q;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_pp
    logic [SW-1:0] mag;
    logic [RW-1:0] rad;
    assign mag = (l % 2 == 1) ? s7_my_q : s7_mx_q;
    assign rad = (l >= 2) ? s7_pl_q.geo.r2 : s7_pl_q.geo.r1;
    always_ff @(posedge clk_i) begin
      s8_lo_q[l] <= (LW+RW)'(mag[LW-1:0]) * (LW+RW)'(rad);
      s8_hi_q[l] <= (HW+RW)'(mag[SW-1:LW]) * (HW+RW)'(rad);
    end
  end

  always_ff @(posedge clk_i) begin
    s8_pl_q <= s7_pl_q;
  end

  // --------------------------------------------------------------------------
  // S9: dividends with the rounding half added
  // --------------------------------------------------------------------------
  logic          s9_vld_q;
  cpct_pkg::pl_t s9_pl_q;
  logic [PW-1:0] s9_num_q [NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_pl_q <= s8_pl_q;
    for (int l = 0; l < NL; l++) begin
      s9_num_q[l] <= (PW'(s8_hi_q[l]) << LW) + PW'(s8_lo_q[l]) + PW'(s8_pl_q.s >> 1);
    end
  end

  // --------------------------------------------------------------------------
  // Rounding divider by S, one quotient bit per stage, four lanes
  // --------------------------------------------------------------------------
  logic          dv_vld_q [QB];
  cpct_pkg::pl_t dv_pl_q  [QB];
  logic [PW-1:0] dv_rem_q [QB][NL];
  logic [QB-1:0] dv_quo_q [QB][NL];

  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int B = QB - 1 - i;
    logic          vld_in;
    cpct_pkg::pl_t pl_in;
    logic [PW-1:0] rem_in [NL];
    logic [QB-1:0] quo_in [NL];
    logic [PW-1:0] trial;

    if (i == 0) begin : g_head
      assign vld_in = s9_vld_q;
      assign pl_in  = s9_pl_q;
      for (genvar l = 0; l < NL; l++) begin : g_ln
        assign rem_in[l] = s9_num_q[l];
        assign quo_in[l] = '0;
      end
    end else begin : g_body
      assign vld_in = dv_vld_q[i-1];
      assign pl_in  = dv_pl_q[i-1];
      for (genvar l = 0; l < NL; l++) begin : g_ln
        assign rem_in[l] = dv_rem_q[i-1][l];
        assign quo_in[l] = dv_quo_q[i-1][l];
      end
    end

    assign trial = PW'(pl_in.s) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i] <= 1'b0;
      end else begin
        dv_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_pl_q[i] <= pl_in;
      for (int l = 0; l < NL; l++) begin
        if (rem_in[l] >= trial) begin
          dv_rem_q[i][l] <= rem_in[l] - trial;
          dv_quo_q[i][l] <= quo_in[l] | (QB'(1) << B);
        end else begin
          dv_rem_q[i][l] <= rem_in[l];
          dv_quo_q[i][l] <= quo_in[l];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output beat: offset from the centers, saturate, zero unfilled slots
  // --------------------------------------------------------------------------
  cpct_pkg::pl_t fin_pl;
  logic          done_q;
  logic [1:0]    slot_q;
  logic          lv_q, last_q;
  logic [CW-1:0] tfx_q, tfy_q, tsx_q, tsy_q;

  assign fin_pl = dv_pl_q[QB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= fin_pl.geo.slot;
    last_q <= (fin_pl.geo.slot == cpct_pkg::SLOT_LAST);
    lv_q   <= fin_pl.line_ok;
    if (fin_pl.line_ok) begin
      tfx_q <= cpct_pkg::sat_add(fin_pl.geo.ax, dv_quo_q[QB-1][0], fin_pl.neg[0]);
      tfy_q <= cpct_pkg::sat_add(fin_pl.geo.ay, dv_quo_q[QB-1][1], fin_pl.neg[1]);
      tsx_q <= cpct_pkg::sat_add(fin_pl.geo.bx, dv_quo_q[QB-1][2],
                                 fin_pl.neg[0] ^ fin_pl.inner);
      tsy_q <= cpct_pkg::sat_add(fin_pl.geo.by, dv_quo_q[QB-1][3],
                                 fin_pl.neg[1] ^ fin_pl.inner);
    end else begin
      tfx_q <= '0;
      tfy_q <= '0;
      tsx_q <= '0;
      tsy_q <= '0;
    end
  end

  assign done_o           = done_q;
  assign slot_index_o     = slot_q;
  assign line_valid_o     = lv_q;
  assign touch_first_x_o  = tfx_q;
  assign touch_first_y_o  = tfy_q;
  assign touch_second_x_o = tsx_q;
  assign touch_second_y_o = tsy_q;
  assign last_slot_o      = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // first slot beat of a command leaves after the fixed pipeline latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT (done_o && slot_index_o == cpct_pkg::SLOT_FIRST))
    else $error("first slot beat missing at fixed latency");

  // slot beats of one pair leave on consecutive cycles in order
  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && slot_index_o != cpct_pkg::SLOT_LAST) |=>
      (done_o && slot_index_o == $past(slot_index_o) + 2'd1))
    else $error("slot beats out of order or broken");

  // an unfilled slot carries zero touch points
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !line_valid_o) |->
      (touch_first_x_o == '0 && touch_first_y_o == '0 &&
       touch_second_x_o == '0 && touch_second_y_o == '0))
    else $error("unfilled slot with nonzero touch point");

endmodule
